// ===== rtl/pcef_pkg.sv =====
// ----------------------------------------------------------------------------
// Prewitt compass edge filter package
// Shared types, constants and window selection for the edge filter.
// ----------------------------------------------------------------------------
package pcef_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int AddrW     = $clog2(MaxWidth);

  localparam logic [2:0] CfgWidth  = 3'd0;
  localparam logic [2:0] CfgHeight = 3'd1;
  localparam logic [2:0] CfgThLo   = 3'd2;
  localparam logic [2:0] CfgThHi   = 3'd3;
  localparam logic [2:0] CfgShift  = 3'd4;
  localparam logic [2:0] CfgPmax   = 3'd5;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] th_lo;
    logic [15:0] th_hi;
    logic [3:0]  shift;
    logic [15:0] pmax;
  } cfg_t;

  typedef logic [8:0][15:0] win_t;

  typedef struct packed {
    logic [7:0][15:0] ring;
    logic [15:0]      ctr;
    logic [11:0]      row;
    logic [11:0]      col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic        last;
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] edge_value;
  } res_t;

  function automatic logic [3:0] widx(logic [1:0] c, logic [1:0] r);
    widx = 4'(c) * 4'd3 + 4'(r);
  endfunction

  function automatic job_t pick(win_t w, logic [1:0] lc, logic [1:0] cc, logic [1:0] rc,
                                logic [1:0] tr, logic [1:0] mr, logic [1:0] br);
    job_t j;
    j      = '0;
    j.ring[0] = w[widx(lc, tr)];
    j.ring[1] = w[widx(cc, tr)];
    j.ring[2] = w[widx(rc, tr)];
    j.ring[3] = w[widx(rc, mr)];
    j.ring[4] = w[widx(rc, br)];
    j.ring[5] = w[widx(cc, br)];
    j.ring[6] = w[widx(lc, br)];
    j.ring[7] = w[widx(lc, mr)];
    j.ctr     = w[widx(cc, mr)];
    pick = j;
  endfunction

endpackage

// ===== rtl/pcef_front.sv =====
// ----------------------------------------------------------------------------
// Edge filter front end
// Accepts pixels, keeps the line stores and window, and issues result jobs.
// ----------------------------------------------------------------------------
module pcef_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcef_pkg::cfg_t cfg_i,
  input  logic          pix_valid_i,
  output logic          pix_ready_o,
  input  logic [15:0]   pix_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output pcef_pkg::job_t job_o
);
  import pcef_pkg::*;

  logic [12:0] wc, hc;
  logic [11:0] col_q, row_q, xcur, ycur;
  logic        xend, ylast, s_acc;

  logic              a_valid_q;
  logic [15:0]       a_pix_q;
  logic [11:0]       a_x_q, a_y_q;
  logic              a_xend_q, a_ylast_q;
  logic [31:0]       rd_q;
  logic [31:0]       mem [MaxWidth];

  win_t        g_win_q;
  logic [3:0]  g_mask_q;
  logic [11:0] g_x_q, g_y_q;
  logic        push, gen_free, a_adv;
  logic [1:0]  lc, top;

  always_comb begin
    wc = (cfg_i.width < 13'd2) ? 13'd2 :
         (cfg_i.width > 13'(MaxWidth)) ? 13'(MaxWidth) : cfg_i.width;
    hc = (cfg_i.height < 13'd2) ? 13'd2 :
         (cfg_i.height > 13'(MaxHeight)) ? 13'(MaxHeight) : cfg_i.height;
    xcur  = ({1'b0, col_q} >= wc) ? 12'(wc - 13'd1) : col_q;
    ycur  = ({1'b0, row_q} >= hc) ? 12'(hc - 13'd1) : row_q;
    xend  = ({1'b0, xcur} == wc - 13'd1);
    ylast = ({1'b0, ycur} == hc - 13'd1);
  end

  assign push     = (g_mask_q != 4'd0) && job_ready_i;
  assign gen_free = (g_mask_q == 4'd0) || (push && ((g_mask_q & (g_mask_q - 4'd1)) == 4'd0));
  assign a_adv    = a_valid_q && gen_free;
  assign pix_ready_o = !a_valid_q || a_adv;
  assign s_acc    = pix_valid_i && pix_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      g_mask_q  <= '0;
      g_win_q   <= '0;
    end else begin
      if (s_acc) begin
        if (xend) begin
          col_q <= '0;
          row_q <= ylast ? 12'd0 : ycur + 12'd1;
        end else begin
          col_q <= xcur + 12'd1;
          row_q <= ycur;
        end
      end
      if (s_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        g_win_q[5:0] <= g_win_q[8:3];
        g_win_q[6]   <= rd_q[31:16];
        g_win_q[7]   <= rd_q[15:0];
        g_win_q[8]   <= a_pix_q;
        g_mask_q     <= (a_x_q != 12'd0 && a_y_q != 12'd0) ?
                        {a_xend_q & a_ylast_q, a_xend_q, a_ylast_q, 1'b1} : 4'd0;
      end else if (push) begin
        g_mask_q <= g_mask_q & (g_mask_q - 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_pix_q   <= pix_i;
      a_x_q     <= xcur;
      a_y_q     <= ycur;
      a_xend_q  <= xend;
      a_ylast_q <= ylast;
      rd_q      <= mem[xcur[AddrW-1:0]];
    end
    if (a_adv) begin
      mem[a_x_q[AddrW-1:0]] <= {rd_q[15:0], a_pix_q};
      g_x_q <= a_x_q;
      g_y_q <= a_y_q;
    end
  end

  assign lc  = (g_x_q == 12'd1) ? 2'd2 : 2'd0;
  assign top = (g_y_q == 12'd1) ? 2'd2 : 2'd0;
  assign job_valid_o = (g_mask_q != 4'd0);

  always_comb begin
    job_o = pick(g_win_q, lc, 2'd1, 2'd2, top, 2'd1, 2'd2);
    job_o.row  = g_y_q - 12'd1;
    job_o.col  = g_x_q - 12'd1;
    job_o.last = 1'b0;
    if (g_mask_q[0]) begin
      job_o = pick(g_win_q, lc, 2'd1, 2'd2, top, 2'd1, 2'd2);
      job_o.row  = g_y_q - 12'd1;
      job_o.col  = g_x_q - 12'd1;
      job_o.last = 1'b0;
    end else if (g_mask_q[1]) begin
      job_o = pick(g_win_q, lc, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1);
      job_o.row  = g_y_q;
      job_o.col  = g_x_q - 12'd1;
      job_o.last = 1'b0;
    end else if (g_mask_q[2]) begin
      job_o = pick(g_win_q, 2'd1, 2'd2, 2'd1, top, 2'd1, 2'd2);
      job_o.row  = g_y_q - 12'd1;
      job_o.col  = g_x_q;
      job_o.last = 1'b0;
    end else if (g_mask_q[3]) begin
      job_o = pick(g_win_q, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1);
      job_o.row  = g_y_q;
      job_o.col  = g_x_q;
      job_o.last = 1'b1;
    end
  end

endmodule

// ===== rtl/pcef_queue.sv =====
// ----------------------------------------------------------------------------
// Edge filter job queue
// Four-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pcef_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  pcef_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output pcef_pkg::job_t rd_data_o
);
  import pcef_pkg::*;

  job_t       q_mem [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_data_o  = q_mem[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) q_mem[wp_q] <= wr_data_i;
  end

endmodule

// ===== rtl/pcef_back.sv =====
// ----------------------------------------------------------------------------
// Edge filter back end
// Evaluates the eight compass masks, takes the maximum and thresholds it.
// ----------------------------------------------------------------------------
module pcef_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcef_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  pcef_pkg::job_t job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output pcef_pkg::res_t res_o
);
  import pcef_pkg::*;

  logic               s1_v_q, s2_v_q, o_v_q;
  logic               s1_rdy, s2_rdy, o_rdy;
  logic signed [21:0] r_d [8];
  logic signed [21:0] r_q [8];
  logic [11:0]        s1_row_q, s1_col_q, s2_row_q, s2_col_q;
  logic               s1_last_q, s2_last_q;
  logic [20:0]        best_d, best_q;
  logic [20:0]        ab [8];
  logic [20:0]        m4 [4];
  logic [20:0]        m2 [2];
  logic [20:0]        sh;
  logic [15:0]        v, thmin, thmax;
  logic [18:0]        sum, plus;
  res_t               res_q;

  assign o_rdy  = !o_v_q || res_ready_i;
  assign s2_rdy = !s2_v_q || o_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign job_ready_o = s1_rdy;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 8; i++) sum = sum + 19'(job_i.ring[i]);
    for (int i = 0; i < 8; i++) begin
      plus = '0;
      for (int k = 0; k < 5; k++) plus = plus + 19'(job_i.ring[(i + k) % 8]);
      r_d[i] = $signed({2'b00, plus, 1'b0}) - $signed({3'b000, sum})
             - $signed({5'b00000, job_i.ctr, 1'b0});
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) ab[i] = r_q[i][21] ? 21'(-r_q[i]) : r_q[i][20:0];
    for (int i = 0; i < 4; i++) m4[i] = (ab[2*i] > ab[2*i+1]) ? ab[2*i] : ab[2*i+1];
    for (int i = 0; i < 2; i++) m2[i] = (m4[2*i] > m4[2*i+1]) ? m4[2*i] : m4[2*i+1];
    best_d = (m2[0] > m2[1]) ? m2[0] : m2[1];
  end

  always_comb begin
    sh    = best_q >> cfg_i.shift;
    v     = (sh > 21'(cfg_i.pmax)) ? cfg_i.pmax : sh[15:0];
    thmax = (cfg_i.th_hi > cfg_i.pmax) ? cfg_i.pmax : cfg_i.th_hi;
    thmin = (cfg_i.th_lo > cfg_i.pmax) ? cfg_i.pmax : cfg_i.th_lo;
    if (v >= thmax) v = cfg_i.pmax;
    if (v <= thmin) v = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= job_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (o_rdy)  o_v_q  <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && job_valid_i) begin
      r_q       <= r_d;
      s1_row_q  <= job_i.row;
      s1_col_q  <= job_i.col;
      s1_last_q <= job_i.last;
    end
    if (s2_rdy && s1_v_q) begin
      best_q    <= best_d;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
    if (o_rdy && s2_v_q) begin
      res_q.edge_value <= v;
      res_q.row        <= s2_row_q;
      res_q.col        <= s2_col_q;
      res_q.last       <= s2_last_q;
    end
  end

  assign res_valid_o = o_v_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/prewitt_compass_edge_filter_top.sv =====
// ----------------------------------------------------------------------------
// Prewitt compass edge filter top level
// 3x3 compass edge detector on a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one item per pixel.
// Results leave on the m_axis channel, each tagged with its row and column;
// tlast marks the final result of a frame. Registers must be written through
// the cfg channel only while the block is idle; the block itself does not
// enforce this. A pixel's first result passes through the line store read,
// the window and job stage, the job queue, the mask sums, the maximum and
// the threshold output register. One pixel is accepted per cycle unless a
// stall holds it. A pixel that yields several results (row ends and the last
// row) holds the input until its last result is issued; results go out one
// per cycle while the queue has room.
// When the receiver stalls, the output register and the pipeline hold, the
// four-entry queue fills and then the input stalls; nothing is lost.
// Reset clears the position counters, window and pipeline valid bits and
// loads the register defaults. The line stores are not cleared.
// ----------------------------------------------------------------------------
module prewitt_compass_edge_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // edge_value, out_row, out_col
  output logic        m_axis_tlast
);
  import pcef_pkg::*;

  cfg_t cfg_q;
  logic job_v, job_r, q_v, q_r;
  job_t job, qjob;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 13'd1920;
      cfg_q.height <= 13'd1080;
      cfg_q.th_lo  <= 16'd0;
      cfg_q.th_hi  <= 16'hFFFF;
      cfg_q.shift  <= 4'd0;
      cfg_q.pmax   <= 16'hFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWidth:  cfg_q.width  <= cfg_data_i[12:0];
        CfgHeight: cfg_q.height <= cfg_data_i[12:0];
        CfgThLo:   cfg_q.th_lo  <= cfg_data_i;
        CfgThHi:   cfg_q.th_hi  <= cfg_data_i;
        CfgShift:  cfg_q.shift  <= cfg_data_i[3:0];
        CfgPmax:   cfg_q.pmax   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcef_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .pix_valid_i(s_axis_tvalid), .pix_ready_o(s_axis_tready), .pix_i(s_axis_tdata),
    .job_valid_o(job_v), .job_ready_i(job_r), .job_o(job)
  );

  pcef_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(job_v), .wr_ready_o(job_r), .wr_data_i(job),
    .rd_valid_o(q_v), .rd_ready_i(q_r), .rd_data_o(qjob)
  );

  pcef_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .job_valid_i(q_v), .job_ready_o(q_r), .job_i(qjob),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = res[39:0];
  assign m_axis_tlast = res.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prewitt compass edge filter testbench
// Streams whole frames through the filter under several register settings,
// predicts every tagged edge result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
  import pcef_pkg::*;

  typedef struct {
    logic [15:0] edge_value;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } edge_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CfgWidth;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  prewitt_compass_edge_filter_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [12:0] fw = 13'd1920, fh = 13'd1080;
  logic [15:0] th_lo = '0, th_hi = 16'hFFFF, pmax = 16'h00FF;
  logic [3:0]  shamt = '0;
  logic [15:0] store_old [MaxWidth];
  logic [15:0] store_new [MaxWidth];
  logic [15:0] win [9];
  int          row_pos = 0, col_pos = 0;

  logic [15:0] pixel_q [$];
  edge_res_t   edge_q [$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          in_gap = 0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] edge_of(int lc, int cc, int rc, int tr, int mr, int br);
    int ring [8];
    int total, best, ctr, plus, r, v, lo, hi;
    ring[0] = win[lc*3+tr]; ring[1] = win[cc*3+tr]; ring[2] = win[rc*3+tr];
    ring[3] = win[rc*3+mr]; ring[4] = win[rc*3+br]; ring[5] = win[cc*3+br];
    ring[6] = win[lc*3+br]; ring[7] = win[lc*3+mr];
    ctr = win[cc*3+mr];
    total = 0;
    best = 0;
    foreach (ring[i]) total += ring[i];
    for (int i = 0; i < 8; i++) begin
      plus = 0;
      for (int k = 0; k < 5; k++) plus += ring[(i + k) % 8];
      r = 2 * plus - total - 2 * ctr;
      if (r < 0) r = -r;
      if (r > best) best = r;
    end
    v = best >> shamt;
    if (v > pmax) v = pmax;
    hi = (th_hi > pmax) ? pmax : th_hi;
    lo = (th_lo > pmax) ? pmax : th_lo;
    if (v >= hi) v = pmax;
    if (v <= lo) v = 0;
    return v[15:0];
  endfunction

  function automatic void add_edge(logic [15:0] v, int r, int c, bit l);
    edge_res_t e;
    e.edge_value = v;
    e.row = r[11:0];
    e.col = c[11:0];
    e.last = l;
    edge_q.push_back(e);
  endfunction

  function automatic void predict_pixel(logic [15:0] pix);
    int w, h, x, y, top, lc;
    bit lastrow;
    logic [15:0] a, b;
    w = (fw < 2) ? 2 : (fw > MaxWidth) ? MaxWidth : fw;
    h = (fh < 2) ? 2 : (fh > MaxHeight) ? MaxHeight : fh;
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    a = store_old[x];
    b = store_new[x];
    store_old[x] = b;
    store_new[x] = pix;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = a;
    win[7] = b;
    win[8] = pix;
    lastrow = (y == h - 1);
    top = (y == 1) ? 2 : 0;
    if (y >= 1 && x >= 1) begin
      lc = (x == 1) ? 2 : 0;
      add_edge(edge_of(lc, 1, 2, top, 1, 2), y - 1, x - 1, 1'b0);
      if (lastrow) add_edge(edge_of(lc, 1, 2, 1, 2, 1), y, x - 1, 1'b0);
      if (x == w - 1) begin
        add_edge(edge_of(1, 2, 1, top, 1, 2), y - 1, x, 1'b0);
        if (lastrow) add_edge(edge_of(1, 2, 1, 1, 2, 1), y, x, 1'b1);
      end
    end
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = lastrow ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endfunction

  // Pixel driver.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q.pop_front();
        in_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    edge_res_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (edge_q.size() == 0) begin
          report("unexpected result", m_axis_tdata[15:0], -1);
        end else begin
          e = edge_q.pop_front();
          if (m_axis_tdata[15:0] !== e.edge_value)
            report("edge_value", m_axis_tdata[15:0], e.edge_value);
          if (m_axis_tdata[27:16] !== e.row) report("out_row", m_axis_tdata[27:16], e.row);
          if (m_axis_tdata[39:28] !== e.col) report("out_col", m_axis_tdata[39:28], e.col);
          if (m_axis_tlast !== e.last) report("frame_last", m_axis_tlast, e.last);
        end
      end
      m_axis_tready <= (gap_len() == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgWidth:  fw = val[12:0];
      CfgHeight: fh = val[12:0];
      CfgThLo:   th_lo = val;
      CfgThHi:   th_hi = val;
      CfgShift:  shamt = val[3:0];
      CfgPmax:   pmax = val;
      default: ;
    endcase
  endtask

  task automatic setup(int w, int h, int lo, int hi, int sh, int pm);
    write_reg(CfgWidth, 16'(w));
    write_reg(CfgHeight, 16'(h));
    write_reg(CfgThLo, 16'(lo));
    write_reg(CfgThHi, 16'(hi));
    write_reg(CfgShift, 16'(sh));
    write_reg(CfgPmax, 16'(pm));
  endtask

  task automatic run_frame(int w, int h, int pm, bit directed);
    int n;
    logic [15:0] p;
    w = (w < 2) ? 2 : (w > MaxWidth) ? MaxWidth : w;
    h = (h < 2) ? 2 : (h > MaxHeight) ? MaxHeight : h;
    n = w * h;
    for (int i = 0; i < n; i++) begin
      if (directed) p = (i % 3 == 0) ? pm[15:0] : ((i % 5 == 1) ? 16'h0 : 16'(i * 37 % (pm + 1)));
      else if ($urandom_range(0, 19) == 0) p = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 3) == 0) p = $urandom_range(0, 1) ? pm[15:0] : 16'h0;
      else p = 16'($urandom_range(0, pm));
      pixel_q.push_back(p);
    end
    do @(posedge clk_i);
    while (pixel_q.size() > 0 || s_axis_tvalid || edge_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int sent, w, h, pm;
    int pms [4] = '{255, 1023, 4095, 65535};
    foreach (store_old[i]) begin
      store_old[i] = '0;
      store_new[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    setup(5, 4, 0, 65535, 0, 255);
    run_frame(5, 4, 255, 1'b1);
    setup(1, 0, 300, 70, 15, 65535);
    run_frame(1, 0, 65535, 1'b0);

    sent = 0;
    while (sent < 430) begin
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 8);
      pm = pms[$urandom_range(0, 3)];
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: setup(w, h, 0, 65535, $urandom_range(0, 2), pm);
        1: setup(w, h, $urandom_range(0, pm), $urandom_range(0, 65535), $urandom_range(0, 15), pm);
        2: setup(w, h, $urandom_range(0, 65535), $urandom_range(0, pm / 2), 15, pm);
        default: setup(w, h, $urandom_range(0, 40), $urandom_range(pm / 2, pm), $urandom_range(0, 4),
                       $urandom_range(255, 65535));
      endcase
      run_frame(w, h, pmax, 1'b0);
      sent += w * h;
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
